[rtl/aes_rt_pkg.sv]
// Package for the AES round transform unit: request and response structs,
// operation codes, S-box tables and GF(2^8) helpers. No dependencies.
`default_nettype none

package aes_rt_pkg;

  typedef enum logic [2:0] {
    OP_SUB      = 3'd0,
    OP_INV_SUB  = 3'd1,
    OP_SHIFT    = 3'd2,
    OP_INV_SHF  = 3'd3,
    OP_MIX      = 3'd4,
    OP_INV_MIX  = 3'd5,
    OP_ADD_KEY  = 3'd6
  } op_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] state_hi;
    logic [63:0] state_lo;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
  } req_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } rsp_t;

  localparam logic [7:0] XTIME_POLY = 8'h1b;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  // Multiply by x in GF(2^8) modulo 0x11B.
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? XTIME_POLY : 8'h00);
  endfunction

  // Byte k of the state, byte 0 in the top bits.
  function automatic logic [7:0] get_byte(input logic [127:0] s, input int k);
    return s[127 - 8 * k -: 8];
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    t = '0;
    for (int k = 0; k < 16; k++) begin
      t[127 - 8 * k -: 8] = inv ? INV_SBOX[get_byte(s, k)] : SBOX[get_byte(s, k)];
    end
    return t;
  endfunction

  // Byte r of column c takes byte r of column (c + r) mod 4, or gives to it when inverse.
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = get_byte(s, r + 4 * c);
        end else begin
          t[127 - 8 * (r + 4 * c) -: 8] = get_byte(s, r + 4 * ((c + r) % 4));
        end
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0]   a  [4];
    logic [7:0]   x2 [4];
    logic [7:0]   x4 [4];
    logic [7:0]   x8 [4];
    logic [7:0]   m9 [4];
    logic [7:0]   m11[4];
    logic [7:0]   m13[4];
    logic [7:0]   m14[4];
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r]   = get_byte(s, 4 * c + r);
        x2[r]  = xtime(a[r]);
        x4[r]  = xtime(x2[r]);
        x8[r]  = xtime(x4[r]);
        m9[r]  = x8[r] ^ a[r];
        m11[r] = x8[r] ^ x2[r] ^ a[r];
        m13[r] = x8[r] ^ x4[r] ^ a[r];
        m14[r] = x8[r] ^ x4[r] ^ x2[r];
      end
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          t[127 - 8 * (4 * c + r) -: 8] = m14[r] ^ m11[(r + 1) % 4]
                                        ^ m13[(r + 2) % 4] ^ m9[(r + 3) % 4];
        end else begin
          t[127 - 8 * (4 * c + r) -: 8] = x2[r] ^ x2[(r + 1) % 4] ^ a[(r + 1) % 4]
                                        ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
        end
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

[rtl/aes_round_transform_unit.sv]
// AES round transform unit top level: request register, transform logic, result register.
// Depends on aes_rt_pkg for the structs, operation codes, S-box tables and GF helpers.
`default_nettype none

// Applies one AES-128 round transform per request: SubBytes, InvSubBytes, ShiftRows,
// InvShiftRows, MixColumns, InvMixColumns or AddRoundKey, chosen by req_type; code 7
// returns the state unchanged. A request is registered on acceptance and its result is
// registered in the result register once that register is free, and a new request is
// taken every cycle while rsp is not stalled. The S-box lookup
// (sixteen table reads) or the InvMixColumns XOR tree sets the path between the two
// registers. The block keeps no state between requests.
module aes_round_transform_unit
  import aes_rt_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst,
  input  wire  logic req_valid,
  output logic       req_stall,
  input  wire  req_t req,
  output logic       rsp_valid,
  input  wire  logic rsp_stall,
  output rsp_t       rsp
);

  logic         s1_valid;
  req_t         s1_req;
  logic         out_free;
  logic         s1_move;
  logic [127:0] src;
  logic [127:0] xform;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign s1_move   = s1_valid && out_free;
  assign req_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
    if (req_valid && !req_stall) begin
      s1_req <= req;
    end
  end

  assign src = {s1_req.state_hi, s1_req.state_lo};

  always_comb begin
    case (s1_req.req_type)
      OP_SUB:     xform = sub_bytes(src, 1'b0);
      OP_INV_SUB: xform = sub_bytes(src, 1'b1);
      OP_SHIFT:   xform = shift_rows(src, 1'b0);
      OP_INV_SHF: xform = shift_rows(src, 1'b1);
      OP_MIX:     xform = mix_columns(src, 1'b0);
      OP_INV_MIX: xform = mix_columns(src, 1'b1);
      OP_ADD_KEY: xform = src ^ {s1_req.key_hi, s1_req.key_lo};
      default:    xform = src;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= s1_valid;
    end
    if (s1_move) begin
      rsp.result_hi <= xform[127:64];
      rsp.result_lo <= xform[63:0];
    end
  end

  // Back-pressure reaches the request side only when both registers are full.
  assert property (@(posedge clk) disable iff (rst) req_stall |-> (s1_valid && rsp_valid))
    else $error("request stalled while a register is free");

  // A request in the first register moves to the result register when it is free.
  assert property (@(posedge clk) disable iff (rst) s1_move |=> rsp_valid)
    else $error("request lost between registers");

  // Add key result is the XOR of the held state and key.
  assert property (@(posedge clk) disable iff (rst)
    (s1_move && s1_req.req_type == OP_ADD_KEY) |=>
      rsp.result_hi == $past(s1_req.state_hi ^ s1_req.key_hi)
      && rsp.result_lo == $past(s1_req.state_lo ^ s1_req.key_lo))
    else $error("add key result mismatch");

  // Reset empties both registers.
  assert property (@(posedge clk) rst |=> (!s1_valid && !rsp_valid))
    else $error("valid left set after reset");

endmodule

`default_nettype wire

[verif/aes_rt_checker.sv]
// Response checker for the AES round transform unit: predicts each result from the
// accepted request and compares it with the response channel. Uses aes_rt_pkg types.
module aes_rt_checker
  import aes_rt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending,
  output int   checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    req_t src;
    rsp_t want;
  } pending_xform_t;

  pending_xform_t expected_q[$];
  logic [7:0]     fwd_sub [256];
  logic [7:0]     rev_sub [256];
  int             fail_total;
  int             checked_total;

  function automatic logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // a^254 is the field inverse; zero maps to zero.
  function automatic logic [7:0] gf_recip(logic [7:0] a);
    logic [7:0] r;
    logic [7:0] base;
    int         e;
    r    = 8'h01;
    base = a;
    for (e = 254; e != 0; e = e >> 1) begin
      if (e % 2) r = gf_times(r, base);
      base = gf_times(base, base);
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl(logic [7:0] x, int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  initial begin
    logic [7:0] b;
    for (int v = 0; v < 256; v++) begin
      b = gf_recip(8'(v));
      fwd_sub[v] = b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ 8'h63;
      b = rotl(8'(v), 1) ^ rotl(8'(v), 3) ^ rotl(8'(v), 6) ^ 8'h05;
      rev_sub[v] = gf_recip(b);
    end
  end

  function automatic rsp_t transform(req_t r);
    logic [7:0] s     [16];
    logic [7:0] key_b [16];
    logic [7:0] t     [16];
    rsp_t       o;
    for (int i = 0; i < 8; i++) begin
      s[i]         = r.state_hi[63 - 8 * i -: 8];
      s[i + 8]     = r.state_lo[63 - 8 * i -: 8];
      key_b[i]     = r.key_hi[63 - 8 * i -: 8];
      key_b[i + 8] = r.key_lo[63 - 8 * i -: 8];
    end
    t = s;
    case (r.req_type)
      OP_SUB: begin
        for (int i = 0; i < 16; i++) t[i] = fwd_sub[s[i]];
      end
      OP_INV_SUB: begin
        for (int i = 0; i < 16; i++) t[i] = rev_sub[s[i]];
      end
      OP_SHIFT: begin
        for (int c = 0; c < 4; c++)
          for (int row = 0; row < 4; row++)
            t[row + 4 * c] = s[row + 4 * ((c + row) % 4)];
      end
      OP_INV_SHF: begin
        for (int c = 0; c < 4; c++)
          for (int row = 0; row < 4; row++)
            t[row + 4 * ((c + row) % 4)] = s[row + 4 * c];
      end
      OP_MIX: begin
        for (int c = 0; c < 4; c++)
          for (int row = 0; row < 4; row++)
            t[4 * c + row] = gf_times(8'h02, s[4 * c + row])
                           ^ gf_times(8'h03, s[4 * c + (row + 1) % 4])
                           ^ s[4 * c + (row + 2) % 4] ^ s[4 * c + (row + 3) % 4];
      end
      OP_INV_MIX: begin
        for (int c = 0; c < 4; c++)
          for (int row = 0; row < 4; row++)
            t[4 * c + row] = gf_times(8'h0e, s[4 * c + row])
                           ^ gf_times(8'h0b, s[4 * c + (row + 1) % 4])
                           ^ gf_times(8'h0d, s[4 * c + (row + 2) % 4])
                           ^ gf_times(8'h09, s[4 * c + (row + 3) % 4]);
      end
      OP_ADD_KEY: begin
        for (int i = 0; i < 16; i++) t[i] = s[i] ^ key_b[i];
      end
      default: ;  // unused code: pass the state through
    endcase
    for (int i = 0; i < 8; i++) begin
      o.result_hi[63 - 8 * i -: 8] = t[i];
      o.result_lo[63 - 8 * i -: 8] = t[i + 8];
    end
    return o;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns mismatch: %s", $realtime, what);
    fail_total++;
  endtask

  always @(posedge clk) begin : watch
    pending_xform_t entry;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        entry.src  = req;
        entry.want = transform(req);
        expected_q.push_back(entry);
      end
      if (rsp_valid && !rsp_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %h_%h with no request outstanding",
                                    rsp.result_hi, rsp.result_lo));
        end else begin
          entry = expected_q.pop_front();
          checked_total++;
          if (rsp.result_hi !== entry.want.result_hi)
            report_mismatch($sformatf("op %0d state %h_%h: result_hi %h, want %h",
                                      entry.src.req_type, entry.src.state_hi,
                                      entry.src.state_lo, rsp.result_hi,
                                      entry.want.result_hi));
          if (rsp.result_lo !== entry.want.result_lo)
            report_mismatch($sformatf("op %0d state %h_%h: result_lo %h, want %h",
                                      entry.src.req_type, entry.src.state_hi,
                                      entry.src.state_lo, rsp.result_lo,
                                      entry.want.result_lo));
        end
      end
    end
    fail_count <= fail_total;
    pending    <= expected_q.size();
    checked    <= checked_total;
  end

endmodule

[verif/tb_aes_round_transform_unit.sv]
// Testbench top for aes_round_transform_unit: clock, reset, request and stall stimulus,
// watchdog and verdict. Depends on aes_rt_pkg and the aes_rt_checker module.
module tb_aes_round_transform_unit
  import aes_rt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CLK_PERIOD   = 10;
  localparam int         RANDOM_COUNT = 1800;
  localparam int         CALM_COUNT   = 200;
  localparam int         IDLE_LIMIT   = 1000;
  localparam logic [2:0] OP_UNUSED    = 3'd7;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  req_t req       = '0;
  logic rsp_stall = 1'b0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;

  int fail_count;
  int pending;
  int checked;
  bit calm = 1'b0;
  int op_seen [8];
  int sent = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  aes_round_transform_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  aes_rt_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  function automatic req_t make_request(logic [2:0] op, logic [63:0] sh, logic [63:0] sl,
                                        logic [63:0] kh, logic [63:0] kl);
    req_t r;
    r.req_type = op;
    r.state_hi = sh;
    r.state_lo = sl;
    r.key_hi   = kh;
    r.key_lo   = kl;
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Hold the request until it is taken; an idle burst may come first.
  task automatic send_request(req_t item);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    op_seen[item.req_type]++;
    sent++;
    do @(posedge clk); while (req_stall);
  endtask

  initial begin : rsp_stall_gen
    while (rst) @(posedge clk);
    forever begin
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, pending);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    logic [63:0] a;
    logic [63:0] b;
    logic [2:0]  op;
    int          pick;
    int          fewest;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Extremes of state and key under every code, key ignored off add key.
    for (int c = 0; c < 8; c++) begin
      send_request(make_request(3'(c), '0, '0, '1, '1));
      send_request(make_request(3'(c), '1, '1, '0, '0));
    end
    send_request(make_request(OP_SUB, 64'h0011223344556677, 64'h8899aabbccddeeff,
                              rand_word(), rand_word()));
    send_request(make_request(OP_INV_SUB, 64'h6363636363636363, 64'h0052091b7c63ff00,
                              '0, '0));
    send_request(make_request(OP_MIX, 64'hdb135345f20a225c, 64'h01010101c6c6c6c6,
                              '1, '0));
    send_request(make_request(OP_INV_MIX, 64'h8e4da1bc9fdc589d, 64'h01010101c6c6c6c6,
                              '0, '1));
    send_request(make_request(OP_SHIFT, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                              '0, '0));
    send_request(make_request(OP_INV_SHF, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                              '1, '1));
    a = {$urandom(), $urandom()};
    b = {$urandom(), $urandom()};
    send_request(make_request(OP_ADD_KEY, a, b, a, b));
    send_request(make_request(OP_ADD_KEY, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
                              64'h5555555555555555, 64'haaaaaaaaaaaaaaaa));
    send_request(make_request(OP_UNUSED, rand_word(), rand_word(), rand_word(),
                              rand_word()));

    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i == RANDOM_COUNT - CALM_COUNT) calm = 1'b1;
      pick = $urandom_range(0, 29);
      op   = (pick < 28) ? 3'(pick % 7) : OP_UNUSED;
      send_request(make_request(op, rand_word(), rand_word(), rand_word(), rand_word()));
    end
    req_valid <= 1'b0;

    // Let the last acceptance reach the checker, then drain.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    fewest = op_seen[0];
    foreach (op_seen[c]) if (op_seen[c] < fewest) fewest = op_seen[c];
    $display("%0d requests over all eight request codes (fewest of one code: %0d),",
             sent, fewest);
    $display("%0d transformed states compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
